// File: design/pmwo_pkg.sv
// ----------------------------------------------------------------------------
// pmwo_pkg
// Shared types, widths and codes for the phase-modulated wavetable
// oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package pmwo_pkg;

   localparam int DATA_W          = 32;
   localparam int PROD_W          = 2 * DATA_W;
   localparam int TABLE_DEPTH     = 1024;
   localparam int ADDR_W          = $clog2(TABLE_DEPTH);
   localparam int INDEX_W         = 10;
   localparam int SELECT_W        = 2;
   localparam int PHASE_FRAC_BITS = 22;
   localparam int CSR_INDEX_W     = 2;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DATA_W-1:0] MOD_BIAS = 32'h7FFF_FFFF;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [SELECT_W-1:0] SEL_CARRIER_A = 2'd0;
   localparam logic [SELECT_W-1:0] SEL_CARRIER_B = 2'd1;
   localparam logic [SELECT_W-1:0] SEL_MODULATOR = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_INCREMENT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOD_DEPTH       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CROSSFADE       = 2'd2;

   typedef enum logic [2:0] {
      KIND_SAMPLE,
      KIND_WRITE_A,
      KIND_WRITE_B,
      KIND_WRITE_MOD,
      KIND_DROP
   } pmwo_kind_type;

   typedef struct packed {
      pmwo_kind_type     kind;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] value;
   } pmwo_entry_type;

   typedef struct packed {
      logic [DATA_W-1:0] phase_increment;
      logic [DATA_W-1:0] mod_depth;
      logic [DATA_W-1:0] crossfade;
   } pmwo_cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_ADDR,
      ST_MUL,
      ST_FIN
   } pmwo_state_type;

endpackage

`default_nettype wire

// File: design/pmwo_ifs.sv
// ----------------------------------------------------------------------------
// pmwo channel interfaces
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmwo_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 operation;
   logic [pmwo_pkg::SELECT_W-1:0]        table_select;
   logic [pmwo_pkg::INDEX_W-1:0]         table_index;
   logic signed [pmwo_pkg::DATA_W-1:0]   table_value;

   modport source (output valid, output operation, output table_select,
                   output table_index, output table_value, input ready);
   modport sink   (input valid, input operation, input table_select,
                   input table_index, input table_value, output ready);
endinterface

interface pmwo_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pmwo_pkg::DATA_W-1:0]   sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// File: design/pmwo_front.sv
// ----------------------------------------------------------------------------
// pmwo_front
// Accepts request items, classifies them and pushes every item not classed as a drop into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pmwo_front (
   pmwo_req_if.sink                  req_chan,
   input  wire logic                 queue_full,
   output logic                      push_valid,
   output pmwo_pkg::pmwo_entry_type  push_entry
);

   pmwo_pkg::pmwo_kind_type kind;
   logic                    index_ok;

   assign index_ok = ({1'b0, req_chan.table_index} <
                      (pmwo_pkg::INDEX_W + 1)'(pmwo_pkg::TABLE_DEPTH));

   always_comb begin
      if (req_chan.operation == pmwo_pkg::OP_SAMPLE) begin
         kind = pmwo_pkg::KIND_SAMPLE;
      end else if (!index_ok) begin
         kind = pmwo_pkg::KIND_DROP;
      end else begin
         case (req_chan.table_select)
            pmwo_pkg::SEL_CARRIER_A: kind = pmwo_pkg::KIND_WRITE_A;
            pmwo_pkg::SEL_CARRIER_B: kind = pmwo_pkg::KIND_WRITE_B;
            pmwo_pkg::SEL_MODULATOR: kind = pmwo_pkg::KIND_WRITE_MOD;
            default:                 kind = pmwo_pkg::KIND_DROP;
         endcase
      end
   end

   assign req_chan.ready   = !queue_full;
   assign push_valid       = req_chan.valid && !queue_full &&
                             (kind != pmwo_pkg::KIND_DROP);
   assign push_entry.kind  = kind;
   assign push_entry.addr  = pmwo_pkg::ADDR_W'(req_chan.table_index);
   assign push_entry.value = req_chan.table_value;

endmodule

`default_nettype wire

// File: design/pmwo_queue.sv
// ----------------------------------------------------------------------------
// pmwo_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pmwo_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   input  wire pmwo_pkg::pmwo_entry_type push_entry,
   output logic                          full,
   input  wire logic                     pop,
   output logic                          pop_valid,
   output pmwo_pkg::pmwo_entry_type      pop_entry
);

   pmwo_pkg::pmwo_entry_type          slot_ff [pmwo_pkg::QUEUE_DEPTH];
   logic [pmwo_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [pmwo_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [pmwo_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push, do_pop;

   assign full      = (count_ff == pmwo_pkg::QCNT_W'(pmwo_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == pmwo_pkg::QPTR_W'(pmwo_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == pmwo_pkg::QPTR_W'(pmwo_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pmwo_pkg::QCNT_W'(pmwo_pkg::QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: design/pmwo_back.sv
// ----------------------------------------------------------------------------
// pmwo_back
// Executes queued items: table writes, and the sample sequence of
// modulator read, depth multiply, carrier reads, mix and output.
// ----------------------------------------------------------------------------
`default_nettype none

module pmwo_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire pmwo_pkg::pmwo_cfg_type   cfg,
   input  wire logic                     q_valid,
   input  wire pmwo_pkg::pmwo_entry_type q_entry,
   output logic                          pop,
   pmwo_rsp_if.source                    rsp_chan
);

   localparam int DW = pmwo_pkg::DATA_W;
   localparam int PW = pmwo_pkg::PROD_W;
   localparam int AW = pmwo_pkg::ADDR_W;

   pmwo_pkg::pmwo_state_type state_ff, state_in;

   logic [DW-1:0] car_a_mem [pmwo_pkg::TABLE_DEPTH];
   logic [DW-1:0] car_b_mem [pmwo_pkg::TABLE_DEPTH];
   logic [DW-1:0] mod_mem   [pmwo_pkg::TABLE_DEPTH];

   logic [DW-1:0]        phase_ff;
   logic [DW-1:0]        mod_rd_ff;
   logic [DW-1:0]        car_a_rd_ff;
   logic [DW-1:0]        car_b_rd_ff;
   logic [DW-1:0]        offset_ff;
   logic signed [PW-1:0] a_prod_ff;
   logic signed [PW-1:0] b_prod_ff;
   logic                 rsp_valid_ff;
   logic [DW-1:0]        rsp_sample_ff;

   logic                 out_free;
   logic                 take_ok;
   logic                 is_sample;
   logic                 wr_a, wr_b, wr_mod;
   logic                 mod_rd_en, car_rd_en, prod_en, phase_en, mul_en, out_load;

   logic [AW-1:0]        mod_raddr;
   logic [AW-1:0]        car_raddr;
   logic [DW-1:0]        biased;
   logic [PW-1:0]        depth_prod;
   logic [DW-1:0]        mod_phase;
   logic signed [PW-1:0] a_prod, b_prod;
   logic signed [PW-1:0] mix;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign take_ok   = (state_ff == pmwo_pkg::ST_IDLE) ||
                      ((state_ff == pmwo_pkg::ST_FIN) && out_free);
   assign is_sample = (q_entry.kind == pmwo_pkg::KIND_SAMPLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pmwo_pkg::ST_IDLE: begin
            if (q_valid && is_sample) begin
               state_in = pmwo_pkg::ST_PROD;
            end
         end
         pmwo_pkg::ST_PROD: state_in = pmwo_pkg::ST_ADDR;
         pmwo_pkg::ST_ADDR: state_in = pmwo_pkg::ST_MUL;
         pmwo_pkg::ST_MUL:  state_in = pmwo_pkg::ST_FIN;
         pmwo_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = (q_valid && is_sample) ? pmwo_pkg::ST_PROD : pmwo_pkg::ST_IDLE;
            end
         end
         default: state_in = pmwo_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pop       = take_ok && q_valid;
      wr_a      = pop && (q_entry.kind == pmwo_pkg::KIND_WRITE_A);
      wr_b      = pop && (q_entry.kind == pmwo_pkg::KIND_WRITE_B);
      wr_mod    = pop && (q_entry.kind == pmwo_pkg::KIND_WRITE_MOD);
      mod_rd_en = pop && is_sample;
      prod_en   = (state_ff == pmwo_pkg::ST_PROD);
      car_rd_en = (state_ff == pmwo_pkg::ST_ADDR);
      phase_en  = (state_ff == pmwo_pkg::ST_ADDR);
      mul_en    = (state_ff == pmwo_pkg::ST_MUL);
      out_load  = (state_ff == pmwo_pkg::ST_FIN) && out_free;
   end

   assign mod_raddr  = AW'(phase_ff >> pmwo_pkg::PHASE_FRAC_BITS);
   assign biased     = mod_rd_ff + pmwo_pkg::MOD_BIAS;
   assign depth_prod = {{DW{1'b0}}, biased} * {{DW{1'b0}}, cfg.mod_depth};
   assign mod_phase  = phase_ff + offset_ff;
   assign car_raddr  = AW'(mod_phase >> pmwo_pkg::PHASE_FRAC_BITS);
   assign a_prod     = $signed({{DW{car_a_rd_ff[DW-1]}}, car_a_rd_ff}) *
                       $signed({{DW{1'b0}}, ~cfg.crossfade});
   assign b_prod     = $signed({{DW{car_b_rd_ff[DW-1]}}, car_b_rd_ff}) *
                       $signed({{DW{1'b0}}, cfg.crossfade});
   assign mix        = a_prod_ff + b_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pmwo_pkg::ST_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (phase_en) begin
            phase_ff <= phase_ff + cfg.phase_increment;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         car_a_mem[q_entry.addr] <= q_entry.value;
      end
      if (car_rd_en) begin
         car_a_rd_ff <= car_a_mem[car_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         car_b_mem[q_entry.addr] <= q_entry.value;
      end
      if (car_rd_en) begin
         car_b_rd_ff <= car_b_mem[car_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_mod) begin
         mod_mem[q_entry.addr] <= q_entry.value;
      end
      if (mod_rd_en) begin
         mod_rd_ff <= mod_mem[mod_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (prod_en) begin
         offset_ff <= depth_prod[PW-1:DW];
      end
      if (mul_en) begin
         a_prod_ff <= a_prod;
         b_prod_ff <= b_prod;
      end
      if (out_load) begin
         rsp_sample_ff <= mix[PW-1:DW];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_sample_ff;

   a_pop_state: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == pmwo_pkg::ST_IDLE || state_ff == pmwo_pkg::ST_FIN))
      else $error("queue popped while a sample is in flight");

   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pmwo_pkg::ST_ADDR) |=> $stable(phase_ff))
      else $error("phase moved outside the address step");

   a_fin_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pmwo_pkg::ST_FIN && !out_free) |=> (state_ff == pmwo_pkg::ST_FIN))
      else $error("sample dropped while output register was busy");

endmodule

`default_nettype wire

// File: design/pm_wavetable_oscillator_unit.sv
// ----------------------------------------------------------------------------
// pm_wavetable_oscillator_unit
// Phase-modulated wavetable oscillator with a crossfade between two carriers.
//
// Request items on req_chan either write one word into carrier A, carrier B
// or the modulator table, or ask for one output sample; a write with an
// unused table select is dropped. Write items give no response; each sample
// item gives one item on rsp_chan. The csr_ port sets the phase increment,
// modulation depth and crossfade; write it only while the unit is idle.
// The back end performs a write item when it pops it. A sample item passes
// through the back-end sequencer (modulator read, depth multiply, carrier
// read, mix multiply) and then the response register. The back end takes the
// next item only once the current sample is in its final step and the
// response register is free.
// A two-entry queue separates request acceptance from execution, and a
// response register holds the finished sample. When the receiver stalls the
// sample waits in that register, the sequencer holds its next result, and
// requests keep entering until the queue is full.
// Reset clears the phase, the control registers and the queue. Table
// contents are not cleared and must be written before they are read.
// ----------------------------------------------------------------------------
`default_nettype none

module pm_wavetable_oscillator_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   pmwo_req_if.sink                                 req_chan,
   pmwo_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_write_enable,
   input  wire logic [pmwo_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [pmwo_pkg::DATA_W-1:0]         csr_write_data
);

   pmwo_pkg::pmwo_cfg_type   cfg_ff;
   pmwo_pkg::pmwo_entry_type push_entry;
   pmwo_pkg::pmwo_entry_type q_entry;
   logic                     push_valid;
   logic                     queue_full;
   logic                     q_valid;
   logic                     pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            pmwo_pkg::CSR_PHASE_INCREMENT: cfg_ff.phase_increment <= csr_write_data;
            pmwo_pkg::CSR_MOD_DEPTH:       cfg_ff.mod_depth       <= csr_write_data;
            pmwo_pkg::CSR_CROSSFADE:       cfg_ff.crossfade       <= csr_write_data;
            default:                       cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   pmwo_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   pmwo_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   pmwo_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// File: test/pm_wavetable_oscillator_unit_test.sv
// ----------------------------------------------------------------------------
// pm_wavetable_oscillator_unit_test
// Self-checking testbench for the phase-modulated wavetable oscillator. Table
// writes and sample requests are queued by a stimulus process. Any table entry
// that a sample would read is loaded first, so that no sample reads an
// unwritten entry. A clocked driver and receiver add random gaps and one long
// response stall. A monitor predicts every sample as requests are accepted
// and compares each response with the oldest prediction.
// ----------------------------------------------------------------------------
module pm_wavetable_oscillator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_W          = pmwo_pkg::DATA_W;
   localparam int PROD_W          = pmwo_pkg::PROD_W;
   localparam int SELECT_W        = pmwo_pkg::SELECT_W;
   localparam int INDEX_W         = pmwo_pkg::INDEX_W;
   localparam int ADDR_W          = pmwo_pkg::ADDR_W;
   localparam int CSR_INDEX_W     = pmwo_pkg::CSR_INDEX_W;
   localparam int TABLE_DEPTH     = pmwo_pkg::TABLE_DEPTH;
   localparam int PHASE_FRAC_BITS = pmwo_pkg::PHASE_FRAC_BITS;

   localparam int PLAN          = 0;
   localparam int LIVE          = 1;
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AT       = 120;

   localparam logic [SELECT_W-1:0] SEL_NONE    = 2'd3;
   localparam logic [DATA_W-1:0]   BIAS_WORD   = 32'h7FFF_FFFF;

   typedef struct packed {
      logic                operation;
      logic [SELECT_W-1:0] table_select;
      logic [INDEX_W-1:0]  table_index;
      logic [DATA_W-1:0]   table_value;
   } osc_req_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DATA_W-1:0]      csr_write_data;

   pmwo_req_if req_bus ();
   pmwo_rsp_if rsp_bus ();

   pm_wavetable_oscillator_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Two copies of the oscillator state: one steers stimulus planning, the
   // other follows the items the block actually accepts.
   logic [DATA_W-1:0] wave_tab  [2][3][TABLE_DEPTH];
   logic [DATA_W-1:0] osc_phase [2] = '{default: '0};
   logic [DATA_W-1:0] step_reg  [2] = '{default: '0};
   logic [DATA_W-1:0] depth_reg [2] = '{default: '0};
   logic [DATA_W-1:0] fade_reg  [2] = '{default: '0};
   bit                loaded    [3][TABLE_DEPTH];

   osc_req_type       stim_items[$];
   logic [DATA_W-1:0] expected_samples[$];

   int   queued_count   = 0;
   int   accepted_count = 0;
   int   sample_count   = 0;
   int   error_count    = 0;
   int   hold_left      = 0;
   bit   hold_done      = 1'b0;
   bit   req_took       = 1'b0;
   bit   timed_out      = 1'b0;
   logic calm;

   assign calm = accepted_count >= 500 && accepted_count < 800;

   always #5ns clock = ~clock;

   function automatic logic [ADDR_W-1:0] tab_addr(input logic [DATA_W-1:0] ph);
      return ADDR_W'((ph >> PHASE_FRAC_BITS) % TABLE_DEPTH);
   endfunction

   function automatic logic [DATA_W-1:0] mod_phase(input int cp);
      logic [DATA_W-1:0] biased;
      logic [PROD_W-1:0] scaled;
      biased = wave_tab[cp][pmwo_pkg::SEL_MODULATOR][tab_addr(osc_phase[cp])] + BIAS_WORD;
      scaled = {{DATA_W{1'b0}}, biased} * {{DATA_W{1'b0}}, depth_reg[cp]};
      return osc_phase[cp] + scaled[PROD_W-1:DATA_W];
   endfunction

   function automatic bit osc_step(input int cp, input osc_req_type item,
                                   output logic [DATA_W-1:0] smp);
      logic [ADDR_W-1:0]        ca;
      logic signed [PROD_W-1:0] a_val;
      logic signed [PROD_W-1:0] b_val;
      logic signed [PROD_W-1:0] a_wt;
      logic signed [PROD_W-1:0] b_wt;
      logic signed [PROD_W-1:0] mix;
      smp = '0;
      if (item.operation == pmwo_pkg::OP_WRITE) begin
         if (item.table_select != SEL_NONE && item.table_index < TABLE_DEPTH) begin
            wave_tab[cp][item.table_select][ADDR_W'(item.table_index)] = item.table_value;
         end
         return 1'b0;
      end
      ca    = tab_addr(mod_phase(cp));
      a_val = $signed(wave_tab[cp][pmwo_pkg::SEL_CARRIER_A][ca]);
      b_val = $signed(wave_tab[cp][pmwo_pkg::SEL_CARRIER_B][ca]);
      a_wt  = {{DATA_W{1'b0}}, ~fade_reg[cp]};
      b_wt  = {{DATA_W{1'b0}}, fade_reg[cp]};
      mix   = a_val * a_wt + b_val * b_wt;
      smp   = mix[PROD_W-1:DATA_W];
      osc_phase[cp] = osc_phase[cp] + step_reg[cp];
      return 1'b1;
   endfunction

   function automatic logic [DATA_W-1:0] random_word();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic osc_req_type make_write(input logic [SELECT_W-1:0] sel,
                                              input logic [INDEX_W-1:0] idx,
                                              input logic [DATA_W-1:0] val);
      osc_req_type item;
      item.operation    = pmwo_pkg::OP_WRITE;
      item.table_select = sel;
      item.table_index  = idx;
      item.table_value  = val;
      return item;
   endfunction

   // Returns 1 when the item is one the block acts on.
   function automatic int queue_item(input osc_req_type item);
      logic [DATA_W-1:0] unused;
      stim_items.push_back(item);
      queued_count++;
      void'(osc_step(PLAN, item, unused));
      if (item.operation == pmwo_pkg::OP_WRITE) begin
         if (item.table_select == SEL_NONE) begin
            return 0;
         end
         loaded[item.table_select][item.table_index] = 1'b1;
      end
      return 1;
   endfunction

   // Loads whatever entries the next sample will read, then asks for it.
   function automatic int queue_sample();
      logic [ADDR_W-1:0] addr;
      osc_req_type       item;
      int                n;
      n    = 0;
      addr = tab_addr(osc_phase[PLAN]);
      if (!loaded[pmwo_pkg::SEL_MODULATOR][addr]) begin
         n += queue_item(make_write(pmwo_pkg::SEL_MODULATOR, addr, random_word()));
      end
      addr = tab_addr(mod_phase(PLAN));
      if (!loaded[pmwo_pkg::SEL_CARRIER_A][addr]) begin
         n += queue_item(make_write(pmwo_pkg::SEL_CARRIER_A, addr, random_word()));
      end
      if (!loaded[pmwo_pkg::SEL_CARRIER_B][addr]) begin
         n += queue_item(make_write(pmwo_pkg::SEL_CARRIER_B, addr, random_word()));
      end
      item.operation    = pmwo_pkg::OP_SAMPLE;
      item.table_select = SELECT_W'($urandom);
      item.table_index  = INDEX_W'($urandom);
      item.table_value  = $urandom;
      n += queue_item(item);
      return n;
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (accepted_count != queued_count || expected_samples.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_register(input logic [CSR_INDEX_W-1:0] idx,
                               input logic [DATA_W-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         pmwo_pkg::CSR_PHASE_INCREMENT: begin
            step_reg[PLAN] = val;
            step_reg[LIVE] = val;
         end
         pmwo_pkg::CSR_MOD_DEPTH: begin
            depth_reg[PLAN] = val;
            depth_reg[LIVE] = val;
         end
         pmwo_pkg::CSR_CROSSFADE: begin
            fade_reg[PLAN] = val;
            fade_reg[LIVE] = val;
         end
         default: ;
      endcase
   endtask

   task automatic set_all(input logic [DATA_W-1:0] step, input logic [DATA_W-1:0] depth,
                          input logic [DATA_W-1:0] fade);
      wait_idle();
      set_register(pmwo_pkg::CSR_PHASE_INCREMENT, step);
      set_register(pmwo_pkg::CSR_MOD_DEPTH, depth);
      set_register(pmwo_pkg::CSR_CROSSFADE, fade);
   endtask

   task automatic run_phase(input logic [DATA_W-1:0] step, input logic [DATA_W-1:0] depth,
                            input logic [DATA_W-1:0] fade, input int count);
      int n;
      int r;
      set_all(step, depth, fade);
      n = 0;
      while (n < count) begin
         r = $urandom_range(99);
         if (r < 55) begin
            n += queue_sample();
         end else if (r < 90) begin
            n += queue_item(make_write(SELECT_W'($urandom_range(2)), INDEX_W'($urandom),
                                       random_word()));
         end else begin
            n += queue_item(make_write(SEL_NONE, INDEX_W'($urandom), $urandom));
         end
      end
   endtask

   task automatic run_stimulus();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      void'(queue_item(make_write(pmwo_pkg::SEL_CARRIER_A, '0, 32'h7FFF_FFFF)));
      void'(queue_item(make_write(pmwo_pkg::SEL_CARRIER_B, '0, 32'h8000_0000)));
      void'(queue_item(make_write(pmwo_pkg::SEL_MODULATOR, '0, 32'h8000_0000)));
      void'(queue_item(make_write(SEL_NONE, '0, 32'hFFFF_FFFF)));
      void'(queue_sample());
      void'(queue_sample());
      void'(queue_item(make_write(pmwo_pkg::SEL_CARRIER_A, INDEX_W'(1023), 32'h0000_0000)));
      void'(queue_item(make_write(pmwo_pkg::SEL_CARRIER_B, INDEX_W'(1023), 32'hFFFF_FFFF)));
      void'(queue_item(make_write(pmwo_pkg::SEL_MODULATOR, INDEX_W'(1023), 32'h7FFF_FFFF)));
      void'(queue_item(make_write(SEL_NONE, INDEX_W'(1023), 32'h0000_0000)));
      set_all('1, '1, '1);
      repeat (4) void'(queue_sample());
      set_all(32'h0040_0000, 32'h8000_0000, 32'h8000_0000);
      repeat (4) void'(queue_sample());
      set_all('0, '0, '1);
      repeat (2) void'(queue_sample());

      run_phase(32'h0040_0000, '0, '0, 190);
      run_phase($urandom, $urandom, $urandom, 190);
      run_phase('0, '1, 32'h8000_0000, 190);
      run_phase($urandom_range(32'h00FF_FFFF), $urandom, '1, 190);
      run_phase('1, '0, $urandom, 190);
      run_phase($urandom, $urandom, $urandom, 190);
      run_phase($urandom, 32'h0000_0001, '0, 150);
      wait_idle();
   endtask

   task automatic watch_for_stall();
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      timed_out = 1'b1;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_took) begin
         if (req_took) begin
            void'(stim_items.pop_front());
         end
         if (stim_items.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
            req_bus.valid        <= 1'b1;
            req_bus.operation    <= stim_items[0].operation;
            req_bus.table_select <= stim_items[0].table_select;
            req_bus.table_index  <= stim_items[0].table_index;
            req_bus.table_value  <= stim_items[0].table_value;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && sample_count >= HOLD_AT) begin
         hold_done     <= 1'b1;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(99) >= 12);
      end
   end

   always @(posedge clock) begin
      osc_req_type       item;
      logic [DATA_W-1:0] smp;
      logic [DATA_W-1:0] want;
      req_took <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            accepted_count <= accepted_count + 1;
            item = {req_bus.operation, req_bus.table_select, req_bus.table_index,
                    req_bus.table_value};
            if (osc_step(LIVE, item, smp)) begin
               expected_samples.push_back(smp);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sample_count <= sample_count + 1;
            if (expected_samples.size() == 0) begin
               $error("sample_out: expected no item, got %0d", $signed(rsp_bus.sample_out));
               error_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_bus.sample_out !== want) begin
                  $error("sample_out: expected %0d, got %0d", $signed(want),
                         $signed(rsp_bus.sample_out));
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.operation    = pmwo_pkg::OP_WRITE;
      req_bus.table_select = pmwo_pkg::SEL_CARRIER_A;
      req_bus.table_index  = '0;
      req_bus.table_value  = '0;
      rsp_bus.ready        = 1'b0;
      csr_write_enable     = 1'b0;
      csr_index            = pmwo_pkg::CSR_PHASE_INCREMENT;
      csr_write_data       = '0;
      fork
         run_stimulus();
         watch_for_stall();
      join_any
      if (!timed_out && error_count == 0 && expected_samples.size() == 0) begin
         $display("pm_wavetable_oscillator_unit_test: PASS");
      end else begin
         $display("pm_wavetable_oscillator_unit_test: FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
design/pmwo_pkg.sv
design/pmwo_ifs.sv
design/pmwo_front.sv
design/pmwo_queue.sv
design/pmwo_back.sv
design/pm_wavetable_oscillator_unit.sv
test/pm_wavetable_oscillator_unit_test.sv
